>>> rtl/core/psrv_pkg.sv
// Package of shared types and constants for the prefix sum range variance unit.
package psrv_pkg;

	localparam int MaxElements  = 1024;
	localparam int ValueBits    = 16;
	localparam int FractionBits = 8;
	localparam int IdxW         = 10;
	localparam int CntW         = 11;
	localparam int SumW         = 27;
	localparam int SqW          = 41;
	localparam int VarW         = 39;
	localparam int NumW         = 52;
	localparam int DenW         = 21;
	localparam int QuoW         = NumW + FractionBits;

	localparam logic [1:0] CmdAppend  = 2'd0;
	localparam logic [1:0] CmdQuery   = 2'd1;
	localparam logic [1:0] CmdRestart = 2'd2;

	localparam logic [1:0] StatOk    = 2'd0;
	localparam logic [1:0] StatRange = 2'd1;
	localparam logic [1:0] StatFull  = 2'd2;

	typedef enum logic [1:0] {
		OpAppend,
		OpQuery,
		OpDone
	} op_t;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		op_t                   op;
		logic [1:0]            status;
		logic signed [15:0]    value;
		logic [IdxW-1:0]       first;
		logic [IdxW-1:0]       last;
		logic [CntW-1:0]       count;
	} job_t;

endpackage

>>> rtl/core/psrv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module psrv_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/psrv_front.sv
// Front part: accepts items, tracks the element count and classifies each item.
module psrv_front import psrv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic [1:0]           cmd,
	input  logic signed [15:0]   element_value,
	input  logic [IdxW-1:0]      first_index,
	input  logic [IdxW-1:0]      last_index,
	output logic                 job_valid,
	output job_t                 job,
	input  logic                 job_stall
);

	logic [CntW-1:0] count_q;
	logic            acc;
	logic [CntW-1:0] next_count;

	assign stall = job_stall;
	assign acc   = valid && !job_stall;

	always_comb begin
		next_count     = count_q;
		job.op         = OpDone;
		job.status     = StatOk;
		job.value      = element_value;
		job.first      = first_index;
		job.last       = last_index;
		case (cmd)
			CmdAppend: begin
				if (count_q >= CntW'(MaxElements)) begin
					job.status = StatFull;
				end else begin
					job.op     = OpAppend;
					next_count = count_q + 1'b1;
				end
			end
			CmdQuery: begin
				if (first_index > last_index || {1'b0, last_index} >= count_q) begin
					job.status = StatRange;
				end else begin
					job.op = OpQuery;
				end
			end
			CmdRestart: next_count = '0;
			default: ;
		endcase
		job.count = next_count;
	end

	assign job_valid = valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= next_count;
		end
	end

endmodule

>>> rtl/core/psrv_queue.sv
// Two-entry queue between the front and back parts.
module psrv_queue import psrv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_stall,
	output job_t out_job
);

	job_t       slot_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_stall  = fill_q == 2'd2;
	assign out_valid = fill_q != 2'd0;
	assign out_job   = slot_q[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/core/psrv_back.sv
// Back part: prefix stores, range arithmetic and a bit-serial divider.
module psrv_back import psrv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_stall,
	input  job_t                      job,
	output logic                      valid,
	input  logic                      stall,
	output logic [1:0]                status,
	output logic signed [SumW-1:0]    range_sum,
	output logic [VarW-1:0]           variance_q8,
	output logic [CntW-1:0]           element_count
);

	typedef enum logic [3:0] {
		StIdle, StRd1, StRd2, StAppW, StDiff, StMul1, StMul2, StSub, StDiv, StOut
	} state_t;

	state_t state_q;
	job_t   job_q;

	logic              ps_we, sq_we;
	logic [IdxW-1:0]   wr_addr, rd_addr;
	logic [SumW-2:0]   ps_wd, ps_rd;
	logic [SqW-1:0]    sq_wd, sq_rd;

	logic signed [SumW-1:0] sum_q, hi_sum_q;
	logic [SqW-1:0]         s2_q, hi_sq_q;
	logic [DenW-1:0]        n_q;
	logic [NumW-1:0]        num_q, sqm_q;
	logic [DenW*2-1:0]      den_q;
	logic [QuoW-1:0]        dvd_q;
	logic [DenW*2:0]        rem_q;
	logic [5:0]             bit_q;
	logic signed [ValueBits*2-1:0] vsq;
	logic [SumW-1:0]        mag;
	logic [DenW*2:0]        trial;

	psrv_ram #(.Width(SumW-1), .Depth(MaxElements)) u_ps (
		.clk(clk), .wr_en(ps_we), .wr_addr(wr_addr), .wr_data(ps_wd),
		.rd_addr(rd_addr), .rd_data(ps_rd)
	);
	psrv_ram #(.Width(SqW), .Depth(MaxElements)) u_sq (
		.clk(clk), .wr_en(sq_we), .wr_addr(wr_addr), .wr_data(sq_wd),
		.rd_addr(rd_addr), .rd_data(sq_rd)
	);

	assign job_stall = state_q != StIdle;
	assign vsq       = job_q.value * job_q.value;
	assign mag       = sum_q[SumW-1] ? -sum_q : sum_q;
	assign wr_addr   = IdxW'(job_q.count - 1'b1);
	assign ps_we     = state_q == StAppW;
	assign sq_we     = ps_we;
	assign ps_wd     = (job_q.count == CntW'(1)) ? (SumW-1)'(job_q.value)
	                   : ps_rd + (SumW-1)'(job_q.value);
	assign sq_wd     = (job_q.count == CntW'(1)) ? SqW'(unsigned'(vsq))
	                   : sq_rd + SqW'(unsigned'(vsq));
	assign trial     = {rem_q[DenW*2-1:0], dvd_q[QuoW-1]} - {1'b0, den_q};

	always_comb begin
		case (state_q)
			StRd1:   rd_addr = (job_q.op == OpAppend) ? IdxW'(job_q.count - 2'd2) : job_q.last;
			StRd2:   rd_addr = job_q.first - 1'b1;
			default: rd_addr = (job_q.op == OpAppend) ? IdxW'(job_q.count - 2'd2) : job_q.last;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			valid   <= 1'b0;
		end else begin
			case (state_q)
				StIdle: begin
					if (job_valid) begin
						job_q <= job;
						case (job.op)
							OpAppend: state_q <= StRd1;
							OpQuery:  state_q <= StRd1;
							default:  state_q <= StOut;
						endcase
					end
				end
				StRd1: begin
					if (job_q.op == OpAppend) begin
						state_q <= StAppW;
					end else begin
						state_q <= StRd2;
					end
				end
				StAppW: state_q <= StOut;
				StRd2: begin
					hi_sum_q <= SumW'(signed'(ps_rd));
					hi_sq_q  <= sq_rd;
					state_q  <= StDiff;
				end
				StDiff: begin
					if (job_q.first == '0) begin
						sum_q <= hi_sum_q;
						s2_q  <= hi_sq_q;
					end else begin
						sum_q <= hi_sum_q - SumW'(signed'(ps_rd));
						s2_q  <= hi_sq_q - sq_rd;
					end
					n_q     <= DenW'(job_q.last - job_q.first) + 1'b1;
					state_q <= StMul1;
				end
				StMul1: begin
					num_q   <= NumW'(n_q[IdxW:0] * s2_q);
					sqm_q   <= NumW'(mag[SumW-2:0] * mag[SumW-2:0]);
					state_q <= StMul2;
				end
				StMul2: begin
					den_q   <= n_q * n_q;
					state_q <= StSub;
				end
				StSub: begin
					dvd_q   <= (num_q >= sqm_q) ? {num_q - sqm_q, FractionBits'(0)} : '0;
					rem_q   <= '0;
					bit_q   <= 6'(QuoW - 1);
					state_q <= StDiv;
				end
				StDiv: begin
					if (!trial[DenW*2]) begin
						rem_q <= trial;
						dvd_q <= {dvd_q[QuoW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[DenW*2-1:0], dvd_q[QuoW-1]};
						dvd_q <= {dvd_q[QuoW-2:0], 1'b0};
					end
					if (bit_q == '0) state_q <= StOut;
					bit_q <= bit_q - 1'b1;
				end
				StOut: begin
					if (!valid || !stall) begin
						valid         <= 1'b1;
						status        <= job_q.status;
						element_count <= job_q.count;
						range_sum     <= (job_q.op == OpQuery) ? sum_q : '0;
						variance_q8   <= (job_q.op == OpQuery) ? VarW'(dvd_q) : '0;
						state_q       <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
			if (valid && !stall && !(state_q == StOut)) valid <= 1'b0;
		end
	end

endmodule

>>> rtl/core/prefix_sum_range_variance_unit.sv
// Top level of the prefix sum range variance unit.
// Items enter on valid/stall: cmd appends an element, queries a range or restarts.
// The front part checks the command against the element count and classifies it,
// then a two-entry queue hands the item to the back part, which owns both stores.
// Each item yields exactly one result item on the output valid/stall channel.
// A query takes longer than any other item:
// a 60-step bit-serial divider sets the query time.
// Prefix stores are RAMs read one address per cycle, written one per append.
// After arst_n the element count is zero and no item is pending.
// When the receiver stalls, the result holds and the queue fills, then input stalls.
// Store contents need no clearing: only written entries are ever read.
module prefix_sum_range_variance_unit import psrv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic signed [15:0]      element_value,
	input  logic [IdxW-1:0]         first_index,
	input  logic [IdxW-1:0]         last_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [SumW-1:0]  range_sum,
	output logic [VarW-1:0]         variance_q8,
	output logic [CntW-1:0]         element_count
);

	logic f_valid, f_stall, b_valid, b_stall;
	job_t f_job, b_job;

	psrv_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall), .cmd(cmd),
		.element_value(element_value), .first_index(first_index),
		.last_index(last_index), .job_valid(f_valid), .job(f_job), .job_stall(f_stall)
	);

	psrv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_stall(f_stall),
		.in_job(f_job), .out_valid(b_valid), .out_stall(b_stall), .out_job(b_job)
	);

	psrv_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(b_valid), .job_stall(b_stall),
		.job(b_job), .valid(out_valid), .stall(out_stall), .status(status),
		.range_sum(range_sum), .variance_q8(variance_q8), .element_count(element_count)
	);

endmodule
